>>> hw/rtl/swaf_pkg.sv
// Shared types and constants for the sliding window anagram finder.
// Standalone package; the top level imports it.
package swaf_pkg;

   localparam int FUNC_W   = 2;
   localparam int LETTER_W = 5;
   localparam int INDEX_W  = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_PATTERN = 2'd1,
      FUNC_TEXT    = 2'd2
   } func_type;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [INDEX_W-1:0]  index_type;

   localparam index_type POS_MAX = '1;

endpackage

>>> hw/rtl/sliding_window_anagram_finder.sv
// Sliding window anagram finder: an accepted text item passes through the stage 1 registers and
// the result queue to rsp_valid; throughput is one item per cycle while req_stall is low, paced by
// the single history memory (one read and one write each cycle) and the letter count cells.
// Reset is synchronous, active high: counts, pattern length, position, ring pointer and
// the result queue clear at once; the history memory needs no clearing, since only
// entries written after the last restart are ever read.
module sliding_window_anagram_finder #(
   parameter int MAX_PAT  = 64,
   parameter int ALPHABET = 26
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swaf_pkg::FUNC_W-1:0]       req_func,
   input  logic [swaf_pkg::LETTER_W-1:0]     req_letter,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [swaf_pkg::INDEX_W-1:0]      rsp_match_index
);
   import swaf_pkg::*;

   // Counts never exceed MAX_PAT; the ring index covers MAX_PAT slots.
   localparam int CNT_W = $clog2(MAX_PAT + 1);
   localparam int AW    = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
   localparam int SW    = AW + 1;

   // ------------------------------------------------------------------
   // State
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] pattern_cnt_ff [ALPHABET];
   logic [CNT_W-1:0] pattern_cnt_in [ALPHABET];
   logic [CNT_W-1:0] window_cnt_ff  [ALPHABET];
   logic [CNT_W-1:0] window_cnt_in  [ALPHABET];
   logic [CNT_W-1:0] plen_ff, plen_in;
   index_type        pos_ff, pos_in;
   logic [AW-1:0]    ring_ff, ring_in;

   // Letter history ring: one write and one registered read per cycle.
   letter_type       history_mem [MAX_PAT];
   letter_type       history_rd_ff;

   // Stage 1: a text item waiting for its old letter from the history memory.
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_remove_ff;
   logic             s1_add_ff;
   logic             s1_emit_ff;
   letter_type       s1_letter_ff;
   index_type        s1_index_ff;

   // Two-entry result queue that parts the result side from the pipeline.
   index_type        q_data_ff [2];
   logic [1:0]       q_cnt_ff, q_cnt_in;
   logic             q_rd_ff, q_rd_in;
   logic             q_wr_ff, q_wr_in;

   // ------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------
   logic       accept;
   logic       pop;
   logic       push;
   logic [2:0] load;

   assign pop       = (q_cnt_ff != 2'd0) && !rsp_stall;
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_match_index = q_data_ff[q_rd_ff];

   // An item taken now may push in the cycle after the stage 1 item pushes; hold off
   // when the queue could not take both.
   assign load      = {1'b0, q_cnt_ff} + {2'b0, s1_valid_ff} - {2'b0, pop};
   assign req_stall = (load >= 3'd2);
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Stage 0: decode the item, advance position and ring, issue the read
   // ------------------------------------------------------------------
   logic             do_clear;
   logic             do_pattern;
   logic             do_text;
   logic             restart;
   logic             letter_ok;
   logic             text_live;
   logic             remove;
   logic             emit;
   logic [INDEX_W:0] pos_plus1;
   logic [SW-1:0]    slot_sum;
   logic [AW-1:0]    old_slot;
   index_type        start_index;

   assign letter_ok = (32'(req_letter) < 32'(ALPHABET));

   always_comb begin
      do_clear   = 1'b0;
      do_pattern = 1'b0;
      do_text    = 1'b0;
      case (req_func)
         FUNC_CLEAR: begin
            do_clear = accept;
         end
         FUNC_PATTERN: begin
            // drop the letter when the pattern is full or the code is out of range
            do_pattern = accept && (plen_ff < CNT_W'(MAX_PAT)) && letter_ok;
         end
         FUNC_TEXT: begin
            do_text = accept;
         end
         default: begin
         end
      endcase
   end

   assign restart   = do_clear || do_pattern;
   assign text_live = do_text && (plen_ff != '0);

   // Oldest letter sits pattern-length slots behind the write slot.
   assign slot_sum = {1'b0, ring_ff} + SW'(MAX_PAT) - SW'(plen_ff);
   assign old_slot = (slot_sum >= SW'(MAX_PAT)) ? AW'(slot_sum - SW'(MAX_PAT))
                                                : AW'(slot_sum);

   assign remove      = (pos_ff >= INDEX_W'(plen_ff));
   assign pos_plus1   = {1'b0, pos_ff} + (INDEX_W+1)'(1);
   assign emit        = (pos_plus1 >= (INDEX_W+1)'(plen_ff));
   assign start_index = pos_ff - INDEX_W'(plen_ff) + INDEX_W'(1);

   always_comb begin
      plen_in = plen_ff;
      pos_in  = pos_ff;
      ring_in = ring_ff;
      if (do_clear) begin
         plen_in = '0;
      end else if (do_pattern) begin
         plen_in = plen_ff + CNT_W'(1);
      end
      if (restart) begin
         pos_in  = '0;
         ring_in = '0;
      end else if (do_text) begin
         // saturate the position; the window keeps sliding
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + INDEX_W'(1);
         end
         if (text_live) begin
            ring_in = (ring_ff == AW'(MAX_PAT - 1)) ? '0 : ring_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0;
         pos_ff  <= '0;
         ring_ff <= '0;
      end else begin
         plen_ff <= plen_in;
         pos_ff  <= pos_in;
         ring_ff <= ring_in;
      end
   end

   // Read-before-write: with a full-length pattern the old slot is the write slot.
   always_ff @(posedge clock) begin
      if (text_live) begin
         history_rd_ff         <= history_mem[old_slot];
         history_mem[ring_ff]  <= req_letter;
      end
   end

   assign s1_valid_in = text_live;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (text_live) begin
         s1_remove_ff <= remove;
         s1_add_ff    <= letter_ok;
         s1_emit_ff   <= emit;
         s1_letter_ff <= req_letter;
         s1_index_ff  <= start_index;
      end
   end

   // ------------------------------------------------------------------
   // Count cells: pattern counts update on a taken pattern letter, window counts
   // on the stage 1 item. A restart in stage 0 wins over the older stage 1 update.
   // ------------------------------------------------------------------
   logic window_match;

   always_comb begin
      window_match = 1'b1;
      for (int k = 0; k < ALPHABET; k++) begin
         pattern_cnt_in[k] = pattern_cnt_ff[k];
         if (do_pattern && (32'(req_letter) == k)) begin
            pattern_cnt_in[k] = pattern_cnt_ff[k] + CNT_W'(1);
         end

         window_cnt_in[k] = window_cnt_ff[k];
         if (s1_valid_ff) begin
            if (s1_remove_ff && (32'(history_rd_ff) == k) && (window_cnt_ff[k] != '0)) begin
               window_cnt_in[k] = window_cnt_in[k] - CNT_W'(1);
            end
            if (s1_add_ff && (32'(s1_letter_ff) == k)) begin
               window_cnt_in[k] = window_cnt_in[k] + CNT_W'(1);
            end
         end
         // compare against the pattern as it stood when this item was taken
         if (window_cnt_in[k] != pattern_cnt_ff[k]) begin
            window_match = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ALPHABET; k++) begin
         if (reset || do_clear) begin
            pattern_cnt_ff[k] <= '0;
         end else begin
            pattern_cnt_ff[k] <= pattern_cnt_in[k];
         end
         if (reset || restart) begin
            window_cnt_ff[k] <= '0;
         end else begin
            window_cnt_ff[k] <= window_cnt_in[k];
         end
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   assign push = s1_valid_ff && s1_emit_ff && window_match;

   always_comb begin
      q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};
      q_rd_in  = pop  ? !q_rd_ff : q_rd_ff;
      q_wr_in  = push ? !q_wr_ff : q_wr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_rd_ff  <= 1'b0;
         q_wr_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         q_rd_ff  <= q_rd_in;
         q_wr_ff  <= q_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[q_wr_ff] <= s1_index_ff;
      end
   end

endmodule
